### src/gtg_pkg.sv
package gtg_pkg;

  typedef logic signed [32:0] mul_op_t;
  typedef logic signed [65:0] mul_prod_t;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_POSE   = 2'd1;
  localparam logic [1:0] KIND_GOAL   = 2'd2;
  localparam logic [1:0] KIND_CANCEL = 2'd3;

  localparam logic [2:0] REG_LIN_GAIN   = 3'd0;
  localparam logic [2:0] REG_ANG_P_GAIN = 3'd1;
  localparam logic [2:0] REG_ANG_D_GAIN = 3'd2;
  localparam logic [2:0] REG_ARRIVE_TOL = 3'd3;
  localparam logic [2:0] REG_LIN_LIMIT  = 3'd4;
  localparam logic [2:0] REG_ANG_LIMIT  = 3'd5;

  localparam int PI_Q12       = 12868;
  localparam int HALF_PI_Q12  = 6434;
  localparam int TWO_PI_Q12   = 25736;
  localparam int MAX_DT_US    = 500000;
  localparam int INV_GAIN_Q20 = 636751;
  localparam int US_PER_S     = 1000000;

  // Arctangent of 2^-i in Q0.30; beyond the table the angle equals 2^-i.
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0: a = 30'd843314857;
      5'd1: a = 30'd497837830;
      5'd2: a = 30'd263043837;
      5'd3: a = 30'd133525159;
      5'd4: a = 30'd67021687;
      5'd5: a = 30'd33543516;
      5'd6: a = 30'd16775851;
      5'd7: a = 30'd8388437;
      5'd8: a = 30'd4194283;
      5'd9: a = 30'd2097149;
      default: a = 30'((31'd1 << 30) >> i);
    endcase
    return a;
  endfunction

endpackage

### src/gtg_mul.sv
module gtg_mul (
  input  logic              clk,
  input  gtg_pkg::mul_op_t   a,
  input  gtg_pkg::mul_op_t   b,
  output gtg_pkg::mul_prod_t prod
);
  import gtg_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

### src/go_to_goal_pd_steering_core.sv
// Sequence: pose, goal and cancel transactions finish in S_IDLE; a working tick runs
// a vectoring CORDIC, seven multiplies on one shared multiplier and a 15-step
// restoring divider before S_OUT; a stop result goes straight to S_OUT.
// Throughput: one item at a time; s_tready is high only between items.
// Reset (rst, synchronous): registers to their reset values, no pose, no goal.
module go_to_goal_pd_steering_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // pos_x, pos_y, heading, elapsed_us, cancel_flag
  input  logic [1:0]   s_tuser,  // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata,  // lin_vel, ang_vel, dist_error, ang_error, reached_pulse
  output logic         m_tuser,  // debug_valid
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data
);
  import gtg_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS);

  typedef enum logic [4:0] {
    S_IDLE, S_CORD, S_R_LO, S_R_HI, S_R_FIN, S_ARR, S_V, S_P1, S_P2,
    S_D1, S_D2, S_DCHK, S_DIV, S_W, S_OUT
  } state_t;

  localparam logic signed [17:0] PI18      = 18'(PI_Q12);
  localparam logic signed [17:0] TWO_PI18  = 18'(TWO_PI_Q12);
  localparam logic signed [14:0] HALF_PI15 = 15'(HALF_PI_Q12);
  localparam logic signed [34:0] Z_HALF    = 35'sd1686629714;

  function automatic logic signed [14:0] wrap_pi(input logic signed [17:0] a);
    logic signed [17:0] t;
    t = a;
    if (t > PI18) t = t - TWO_PI18;
    if (t > PI18) t = t - TWO_PI18;
    if (t < -PI18) t = t + TWO_PI18;
    if (t < -PI18) t = t + TWO_PI18;
    return t[14:0];
  endfunction

  state_t state;

  logic [15:0] lin_gain, ang_p_gain, ang_d_gain, lin_lim;
  logic [30:0] arrive_tol;
  logic [14:0] ang_lim;

  logic signed [31:0] robot_px, robot_py, target_px, target_py;
  logic signed [14:0] robot_yaw, last_err;
  logic pose_known, target_active, target_done, driving;

  logic signed [43:0] cx, cy;
  logic signed [34:0] cz;
  logic [CW-1:0] cnt;
  logic bzero;
  logic signed [16:0] bear;
  logic [41:0] acc_lo;
  logic [31:0] dist_err;
  logic signed [14:0] err, derr;
  logic [19:0] dtr;
  logic signed [53:0] num;
  logic [53:0] rem;
  logic neg, sat;
  logic [3:0] k;
  logic [14:0] q;
  logic [15:0] res_lin, res_ang;
  logic signed [14:0] res_err;
  logic res_reached, res_valid;

  mul_op_t mul_a, mul_b;
  mul_prod_t prod;

  gtg_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  // Input fields.
  logic signed [31:0] in_px, in_py;
  logic signed [14:0] in_hd;
  logic [19:0] in_dt;
  logic in_flag, accept, dt_ok, tick_go;
  assign in_px   = s_tdata[31:0];
  assign in_py   = s_tdata[63:32];
  assign in_hd   = s_tdata[78:64];
  assign in_dt   = s_tdata[98:79];
  assign in_flag = s_tdata[99];
  assign s_tready = (state == S_IDLE);
  assign accept  = s_tvalid && s_tready;
  assign dt_ok   = (in_dt != 20'd0) && (in_dt <= 20'(MAX_DT_US));
  assign tick_go = dt_ok && pose_known && target_active && !target_done;

  logic signed [32:0] dx, dy;
  logic signed [43:0] x0, y0;
  assign dx = {target_px[31], target_px} - {robot_px[31], robot_px};
  assign dy = {target_py[31], target_py} - {robot_py[31], robot_py};
  assign x0 = {{3{dx[32]}}, dx, 8'b0};
  assign y0 = {{3{dy[32]}}, dy, 8'b0};

  logic signed [43:0] xs, ys;
  logic signed [34:0] at, zr;
  assign xs = cx >>> cnt;
  assign ys = cy >>> cnt;
  assign at = {5'b0, atan_entry(5'(cnt))};
  assign zr = cz + 35'sd131072;

  logic [67:0] rsum;
  logic [39:0] rq;
  assign rsum = 68'(acc_lo) + (68'(prod[41:0]) << 22) + 68'd134217728;
  assign rq   = rsum[67:28];

  logic [31:0] v_full;
  logic e_wide;
  assign v_full = prod[47:16];
  assign e_wide = (err > HALF_PI15) || (err < -HALF_PI15);

  logic [53:0] magv, den_ext, dsh;
  assign magv    = num[53] ? 54'(-num) : 54'(num);
  assign den_ext = {22'b0, dtr, 12'b0};
  assign dsh     = den_ext << k;

  logic [14:0] wm;
  assign wm = (sat || (q > ang_lim)) ? ang_lim : q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_R_LO: begin
        mul_a = {11'b0, cx[21:0]};
        mul_b = 33'(INV_GAIN_Q20);
      end
      S_R_HI: begin
        mul_a = {11'b0, cx[43:22]};
        mul_b = 33'(INV_GAIN_Q20);
      end
      S_ARR: begin
        mul_a = {17'b0, lin_gain};
        mul_b = {1'b0, dist_err};
      end
      S_V: begin
        mul_a = {17'b0, ang_p_gain};
        mul_b = {{18{err[14]}}, err};
      end
      S_P1: begin
        mul_a = prod[32:0];
        mul_b = {13'b0, dtr};
      end
      S_P2: begin
        mul_a = {17'b0, ang_d_gain};
        mul_b = {{18{derr[14]}}, derr};
      end
      S_D1: begin
        mul_a = prod[32:0];
        mul_b = 33'(US_PER_S);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lin_gain <= 16'd128;
      ang_p_gain <= 16'd512;
      ang_d_gain <= 16'd26;
      arrive_tol <= 31'd3277;
      lin_lim <= 16'd51;
      ang_lim <= 15'd307;
      robot_px <= '0;
      robot_py <= '0;
      robot_yaw <= '0;
      target_px <= '0;
      target_py <= '0;
      last_err <= '0;
      pose_known <= 1'b0;
      target_active <= 1'b0;
      target_done <= 1'b0;
      driving <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LIN_GAIN:   lin_gain <= cfg_data[15:0];
          REG_ANG_P_GAIN: ang_p_gain <= cfg_data[15:0];
          REG_ANG_D_GAIN: ang_d_gain <= cfg_data[15:0];
          REG_ARRIVE_TOL: arrive_tol <= cfg_data;
          REG_LIN_LIMIT:  lin_lim <= cfg_data[15:0];
          REG_ANG_LIMIT:  ang_lim <= cfg_data[14:0];
          default: ;
        endcase
      end
      // In S_OUT the output register is either held or reloaded below.
      if (m_tvalid && m_tready && (state != S_OUT)) m_tvalid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (s_tuser)
              KIND_POSE: begin
                robot_px <= in_px;
                robot_py <= in_py;
                robot_yaw <= in_hd;
                pose_known <= 1'b1;
              end
              KIND_GOAL: begin
                target_px <= in_px;
                target_py <= in_py;
                target_active <= 1'b1;
                target_done <= 1'b0;
                last_err <= '0;
              end
              KIND_CANCEL: begin
                if (in_flag) begin
                  target_active <= 1'b0;
                  target_done <= 1'b1;
                  driving <= 1'b0;
                  last_err <= '0;
                end
              end
              default: begin
                if (tick_go) begin
                  driving <= 1'b1;
                  dtr <= in_dt;
                  cnt <= '0;
                  bzero <= (dx == 33'sd0) && (dy == 33'sd0);
                  // Bring the vector into the right half plane first.
                  if (x0 < 0) begin
                    if (y0 >= 0) begin
                      cx <= y0;
                      cy <= -x0;
                      cz <= Z_HALF;
                    end else begin
                      cx <= -y0;
                      cy <= x0;
                      cz <= -Z_HALF;
                    end
                  end else begin
                    cx <= x0;
                    cy <= y0;
                    cz <= '0;
                  end
                  state <= S_CORD;
                end else if (driving) begin
                  driving <= 1'b0;
                  res_lin <= '0;
                  res_ang <= '0;
                  dist_err <= '0;
                  res_err <= '0;
                  res_reached <= 1'b0;
                  res_valid <= 1'b0;
                  state <= S_OUT;
                end
              end
            endcase
          end
        end
        S_CORD: begin
          if (cy >= 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + at;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - at;
          end
          if (cnt == CW'(CORDIC_STEPS - 1)) state <= S_R_LO;
          else cnt <= cnt + 1'b1;
        end
        S_R_LO: begin
          bear <= bzero ? 17'sd0 : zr[34:18];
          state <= S_R_HI;
        end
        S_R_HI: begin
          acc_lo <= prod[41:0];
          state <= S_R_FIN;
        end
        S_R_FIN: begin
          dist_err <= (rq[39:32] != 8'd0) ? 32'hFFFF_FFFF : rq[31:0];
          err <= wrap_pi({bear[16], bear} - {{3{robot_yaw[14]}}, robot_yaw});
          state <= S_ARR;
        end
        S_ARR: begin
          if (dist_err < {1'b0, arrive_tol}) begin
            target_done <= 1'b1;
            target_active <= 1'b0;
            res_lin <= '0;
            res_ang <= '0;
            res_err <= '0;
            res_reached <= 1'b1;
            res_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            derr <= wrap_pi({{3{err[14]}}, err} - {{3{last_err[14]}}, last_err});
            last_err <= err;
            state <= S_V;
          end
        end
        S_V: begin
          if (e_wide) res_lin <= '0;
          else if (v_full > {16'b0, lin_lim}) res_lin <= lin_lim;
          else res_lin <= v_full[15:0];
          state <= S_P1;
        end
        S_P1: state <= S_P2;
        S_P2: begin
          num <= prod[53:0];
          state <= S_D1;
        end
        S_D1: state <= S_D2;
        S_D2: begin
          num <= num + prod[53:0];
          state <= S_DCHK;
        end
        S_DCHK: begin
          // A quotient of 2^15 or more is past any turn-rate limit.
          neg <= num[53];
          sat <= magv >= (den_ext << 15);
          rem <= magv;
          k <= 4'd14;
          q <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            q[k] <= 1'b1;
          end
          if (k == 4'd0) state <= S_W;
          else k <= k - 1'b1;
        end
        S_W: begin
          res_ang <= neg ? -{1'b0, wm} : {1'b0, wm};
          res_err <= err;
          res_reached <= 1'b0;
          res_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {res_reached, res_err, dist_err, res_ang, res_lin};
            m_tuser <= res_valid;
            m_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 80'd0)
    else $error("stop result carries nonzero fields");

  a_reach_still: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[79] |-> m_tuser && m_tdata[31:0] == 32'd0)
    else $error("arrival result with motion or without debug_valid");

  a_ang_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:16]) <= $signed({1'b0, ang_lim}))
              && ($signed(m_tdata[31:16]) >= -$signed({1'b0, ang_lim})))
    else $error("turn rate beyond limit");

  a_cancel_stops: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser == KIND_CANCEL && s_tdata[99] |=> !driving && !target_active)
    else $error("cancel did not stop the controller");

endmodule

### dv/go_to_goal_pd_steering_core_test.sv
`timescale 1ns / 1ps

module go_to_goal_pd_steering_core_test;
  import gtg_pkg::*;

  localparam int STEPS = 16;
  localparam int QUIET_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [14:0] hd;
    logic [19:0]        dt;
    logic               flag;
  } item_t;

  typedef struct {
    logic [15:0] lin;
    logic [15:0] ang;
    logic [31:0] dist_err;
    logic [14:0] aerr;
    logic        reached;
    logic        valid;
  } cmd_t;

  typedef enum {CHK_MODEL, CHK_NONE, CHK_STOP, CHK_ARRIVE_AT_ZERO} check_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic [1:0]   s_tuser = KIND_TICK;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [79:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = REG_LIN_GAIN;
  logic [30:0]  cfg_data = '0;

  go_to_goal_pd_steering_core #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Register mirror and steering state.
  longint lin_gain, ang_p_gain, ang_d_gain, arrive_tol, lin_limit, ang_limit;
  longint robot_x, robot_y, robot_yaw, goal_x, goal_y, prev_err;
  bit pose_known, goal_active, goal_done, driving;

  const longint atan_q30[10] = '{843314857, 497837830, 263043837, 133525159, 67021687,
                                 33543516, 16775851, 8388437, 4194283, 2097149};

  cmd_t expected_cmds[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int quiet_count = 0;

  function automatic void steer_step(input item_t it, output bit got, output cmd_t c);
    longint dx, dy, x, y, z, t, xs, ys, bear, e, de, w, dtl;
    longint unsigned r, v;
    got = 1'b0;
    c = '{default: '0};
    if (it.kind == KIND_POSE) begin
      robot_x = it.px; robot_y = it.py; robot_yaw = it.hd; pose_known = 1'b1;
      return;
    end
    if (it.kind == KIND_GOAL) begin
      goal_x = it.px; goal_y = it.py;
      goal_active = 1'b1; goal_done = 1'b0; prev_err = 0;
      return;
    end
    if (it.kind == KIND_CANCEL) begin
      if (it.flag) begin
        goal_active = 1'b0; goal_done = 1'b1; driving = 1'b0; prev_err = 0;
      end
      return;
    end
    dtl = it.dt;
    if (dtl == 0 || dtl > MAX_DT_US || !pose_known || !goal_active || goal_done) begin
      // Losing activity gives exactly one all-zero stop command.
      if (driving) begin
        driving = 1'b0;
        got = 1'b1;
      end
      return;
    end
    driving = 1'b1;
    got = 1'b1;
    dx = goal_x - robot_x;
    dy = goal_y - robot_y;
    x = dx <<< 8;
    y = dy <<< 8;
    z = 0;
    // Pre-rotate the left half-plane by +-pi/2 so CORDIC converges.
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 2 * atan_q30[0];
      end else begin
        t = x; x = -y; y = t; z = -2 * atan_q30[0];
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += (i < 10) ? atan_q30[i] : ((64'sd1 << 30) >>> i);
      end else begin
        x -= ys; y += xs; z -= (i < 10) ? atan_q30[i] : ((64'sd1 << 30) >>> i);
      end
    end
    r = (longint'(x) * INV_GAIN_Q20 + (64'd1 << 27)) >> 28;
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    bear = (dx == 0 && dy == 0) ? 0 : ((z + (64'sd1 << 17)) >>> 18);
    c.dist_err = r[31:0];
    c.valid = 1'b1;
    if (r < longint'(arrive_tol)) begin
      goal_done = 1'b1; goal_active = 1'b0;
      c.reached = 1'b1;
      return;
    end
    e = bear - robot_yaw;
    while (e > PI_Q12) e -= TWO_PI_Q12;
    while (e < -PI_Q12) e += TWO_PI_Q12;
    de = e - prev_err;
    while (de > PI_Q12) de -= TWO_PI_Q12;
    while (de < -PI_Q12) de += TWO_PI_Q12;
    prev_err = e;
    v = (longint'(lin_gain) * r) >> 16;
    if (e > HALF_PI_Q12 || e < -HALF_PI_Q12) v = 0;
    if (v > longint'(lin_limit)) v = lin_limit;
    w = (ang_p_gain * e * dtl + ang_d_gain * de * US_PER_S) / (dtl * 4096);
    if (w > ang_limit) w = ang_limit;
    if (w < -ang_limit) w = -ang_limit;
    c.lin = v[15:0];
    c.ang = w[15:0];
    c.aerr = e[14:0];
  endfunction

  task automatic send_item(input item_t it, input check_t ck);
    bit got;
    cmd_t c;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, it.flag, it.dt, it.hd, it.py, it.px};
    s_tuser <= it.kind;
    do @(posedge clk); while (!s_tready);
    steer_step(it, got, c);
    case (ck)
      CHK_MODEL: if (got) expected_cmds.push_back(c);
      CHK_STOP: expected_cmds.push_back('{default: '0});
      CHK_ARRIVE_AT_ZERO: expected_cmds.push_back('{0, 0, 0, 0, 1'b1, 1'b1});
      default: ;
    endcase
  endtask

  // Hold off the sender until every expected command has come out.
  task automatic drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input longint val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[30:0];
    case (idx)
      REG_LIN_GAIN:   lin_gain = val & 16'hFFFF;
      REG_ANG_P_GAIN: ang_p_gain = val & 16'hFFFF;
      REG_ANG_D_GAIN: ang_d_gain = val & 16'hFFFF;
      REG_ARRIVE_TOL: arrive_tol = val & 31'h7FFF_FFFF;
      REG_LIN_LIMIT:  lin_limit = val & 16'hFFFF;
      REG_ANG_LIMIT:  ang_limit = val & 15'h7FFF;
      default: ;
    endcase
  endtask

  task automatic configure(input longint lg, input longint pg, input longint dg,
                           input longint tol, input longint ll, input longint al);
    write_reg(REG_LIN_GAIN, lg);
    write_reg(REG_ANG_P_GAIN, pg);
    write_reg(REG_ANG_D_GAIN, dg);
    write_reg(REG_ARRIVE_TOL, tol);
    write_reg(REG_LIN_LIMIT, ll);
    write_reg(REG_ANG_LIMIT, al);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic item_t mk(input logic [1:0] kind, input longint px, input longint py,
                               input longint hd, input longint dt, input bit flag);
    mk.kind = kind;
    mk.px = px[31:0];
    mk.py = py[31:0];
    mk.hd = hd[14:0];
    mk.dt = dt[19:0];
    mk.flag = flag;
  endfunction

  function automatic longint rand_pos();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return longint'($signed($urandom()));
    return longint'($urandom_range(524288)) - 262144;
  endfunction

  function automatic item_t rand_item();
    int sel;
    item_t it;
    sel = $urandom_range(99);
    it = mk(KIND_TICK, longint'($signed($urandom())), longint'($signed($urandom())),
            longint'($urandom_range(25736)) - PI_Q12, $urandom_range(1048575),
            $urandom_range(1));
    if (sel < 58) begin
      if ($urandom_range(99) < 8) it.dt = $urandom_range(1) ? 20'd0 : 20'($urandom_range(1048575, 500001));
      else it.dt = 20'($urandom_range(500000, 1));
    end else if (sel < 78) begin
      it.kind = KIND_POSE;
      it.px = rand_pos();
      it.py = rand_pos();
    end else if (sel < 92) begin
      it.kind = KIND_GOAL;
      if ($urandom_range(99) < 20) begin
        // Goal right next to the robot so that arrival can happen.
        it.px = 32'(robot_x + longint'($urandom_range(4000)) - 2000);
        it.py = 32'(robot_y + longint'($urandom_range(4000)) - 2000);
      end else begin
        it.px = rand_pos();
        it.py = rand_pos();
      end
    end else begin
      it.kind = KIND_CANCEL;
      it.flag = ($urandom_range(99) < 70);
    end
    return it;
  endfunction

  task automatic report(input string what, input logic [31:0] seen, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, seen, want, $realtime);
    errors++;
  endtask

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    cmd_t obs, want;
    if (!rst && m_tvalid && m_tready) begin
      obs = '{m_tdata[15:0], m_tdata[31:16], m_tdata[63:32], m_tdata[78:64],
              m_tdata[79], m_tuser};
      if (expected_cmds.size() == 0) begin
        report("unexpected transaction", m_tdata[63:32], 32'h0);
      end else begin
        want = expected_cmds.pop_front();
        if (obs.lin != want.lin) report("lin_vel", obs.lin, want.lin);
        if (obs.ang != want.ang) report("ang_vel", obs.ang, want.ang);
        if (obs.dist_err != want.dist_err) report("dist_error", obs.dist_err, want.dist_err);
        if (obs.aerr != want.aerr) report("ang_error", obs.aerr, want.aerr);
        if (obs.reached != want.reached) report("reached_pulse", obs.reached, want.reached);
        if (obs.valid != want.valid) report("debug_valid", obs.valid, want.valid);
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  item_t  dir_items[$];
  check_t dir_checks[$];

  initial begin
    int sent;
    lin_gain = 128; ang_p_gain = 512; ang_d_gain = 26;
    arrive_tol = 3277; lin_limit = 51; ang_limit = 307;
    robot_x = 0; robot_y = 0; robot_yaw = 0; goal_x = 0; goal_y = 0; prev_err = 0;
    pose_known = 0; goal_active = 0; goal_done = 0; driving = 0;

    dir_items = '{
      mk(KIND_TICK, 0, 0, 0, 1000, 0),
      mk(KIND_POSE, 0, 0, 0, 0, 0),
      mk(KIND_GOAL, 0, 0, 0, 0, 0),
      mk(KIND_TICK, 0, 0, 0, 1000, 0),
      mk(KIND_TICK, 0, 0, 0, 1000, 0),
      mk(KIND_GOAL, 655360, 0, 0, 0, 0),
      mk(KIND_TICK, 0, 0, 0, 1, 0),
      mk(KIND_TICK, 0, 0, 0, 500000, 0),
      mk(KIND_TICK, 0, 0, 0, 500001, 0),
      mk(KIND_TICK, 0, 0, 0, 0, 0),
      mk(KIND_TICK, 0, 0, 0, 50000, 0),
      mk(KIND_POSE, 0, 0, 12868, 0, 0),
      mk(KIND_TICK, 0, 0, 0, 50000, 0),
      mk(KIND_POSE, 0, 0, -12868, 0, 0),
      mk(KIND_TICK, 0, 0, 0, 1048575, 1),
      mk(KIND_TICK, 0, 0, 0, 50000, 0),
      mk(KIND_POSE, -2147483648, -2147483648, 0, 0, 0),
      mk(KIND_GOAL, 2147483647, 2147483647, 0, 0, 0),
      mk(KIND_TICK, 0, 0, 0, 50000, 0),
      mk(KIND_POSE, 0, 0, 0, 0, 0),
      mk(KIND_GOAL, -655360, 0, 0, 0, 0),
      mk(KIND_TICK, 0, 0, 0, 50000, 0),
      mk(KIND_CANCEL, 0, 0, 0, 0, 0),
      mk(KIND_TICK, 0, 0, 0, 50000, 0),
      mk(KIND_CANCEL, 0, 0, 0, 0, 1),
      mk(KIND_TICK, 0, 0, 0, 50000, 0)
    };
    dir_checks = '{
      CHK_NONE, CHK_NONE, CHK_NONE, CHK_ARRIVE_AT_ZERO, CHK_STOP,
      CHK_MODEL, CHK_MODEL, CHK_MODEL, CHK_STOP, CHK_NONE,
      CHK_MODEL, CHK_NONE, CHK_MODEL, CHK_NONE, CHK_STOP,
      CHK_MODEL, CHK_NONE, CHK_NONE, CHK_MODEL, CHK_NONE,
      CHK_NONE, CHK_MODEL, CHK_NONE, CHK_MODEL, CHK_NONE,
      CHK_NONE
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_items[i]) send_item(dir_items[i], dir_checks[i]);

    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: configure(128, 512, 26, 3277, 51, 307);
        1: configure(65535, 65535, 65535, 0, 65535, 32767);
        2: configure(0, 0, 0, 2147483647, 0, 0);
        default: configure($urandom_range(65535), $urandom_range(65535),
                           $urandom_range(65535), $urandom_range(200000),
                           $urandom_range(65535), $urandom_range(32767));
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        if (sent < RANDOM_ITEMS / 3) begin
          send_idle = 33; recv_stall = 79;
        end else if (sent < 2 * RANDOM_ITEMS / 3) begin
          send_idle = 79; recv_stall = 33;
        end else begin
          send_idle = 0; recv_stall = 0;
        end
        send_item(rand_item(), CHK_MODEL);
        sent++;
      end
    end
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
